FILE: rtl/process_slot_allocator_macros.svh
// Assertion helpers for the process slot allocator.
`ifndef PROCESS_SLOT_ALLOCATOR_MACROS_SVH
`define PROCESS_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PSA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Types, codes and defaults shared by the process slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int unsigned SlotsDef    = 8;
  localparam int unsigned RamBytesDef = 8192;
  localparam logic [15:0] BaseReset   = 16'h6000;
  localparam logic [31:0] Signature   = 32'h42524F53;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_MARK  = 2'd2,
    ACT_EXIT  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_HEADER = 2'd1,
    ERR_NOMEM  = 2'd2,
    ERR_SLOT   = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    CALL_NONE  = 2'd0,
    CALL_START = 2'd1,
    CALL_PROC  = 2'd2,
    CALL_EXIT  = 2'd3
  } call_e;

  typedef enum logic [2:0] {
    ST_INACTIVE = 3'd0,
    ST_LOADING  = 3'd1,
    ST_LOADED   = 3'd2,
    ST_RUNNING  = 3'd3,
    ST_EXITING  = 3'd4
  } slot_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] magic;
    logic [15:0] image_size;
    logic [15:0] extra_ram;
    logic [15:0] start_offset;
    logic [15:0] proc_offset;
    logic [15:0] exit_offset;
    logic [3:0]  slot;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [1:0]  error_code;
    logic [3:0]  slot_out;
    logic [15:0] location;
    logic [15:0] start_addr;
    logic [15:0] proc_addr;
    logic [15:0] exit_addr;
    logic [1:0]  call_kind;
    logic [15:0] call_addr;
    logic        last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic alloc_step;
    logic alloc_done;
    logic tick_step;
    logic act_done;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_e action;
    logic    idx_last;
    logic    out_free;
  } sts_t;

endpackage

FILE: rtl/psa_in_if.sv
// ----------------------------------------------------------------------------
// psa_in_if
// Request channel: valid/ready plus the request fields.
// ----------------------------------------------------------------------------
interface psa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] magic;
  logic [15:0] image_size;
  logic [15:0] extra_ram;
  logic [15:0] start_offset;
  logic [15:0] proc_offset;
  logic [15:0] exit_offset;
  logic [3:0]  slot;

  modport source (output valid, action, magic, image_size, extra_ram, start_offset,
                  proc_offset, exit_offset, slot, input ready);
  modport sink   (input valid, action, magic, image_size, extra_ram, start_offset,
                  proc_offset, exit_offset, slot, output ready);
endinterface

FILE: rtl/psa_out_if.sv
// ----------------------------------------------------------------------------
// psa_out_if
// Result channel: valid/ready plus the result fields.
// ----------------------------------------------------------------------------
interface psa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        ok;
  logic [1:0]  error_code;
  logic [3:0]  slot_out;
  logic [15:0] location;
  logic [15:0] start_addr;
  logic [15:0] proc_addr;
  logic [15:0] exit_addr;
  logic [1:0]  call_kind;
  logic [15:0] call_addr;
  logic        last;

  modport source (output valid, kind, ok, error_code, slot_out, location, start_addr,
                  proc_addr, exit_addr, call_kind, call_addr, last, input ready);
  modport sink   (input valid, kind, ok, error_code, slot_out, location, start_addr,
                  proc_addr, exit_addr, call_kind, call_addr, last, output ready);
endinterface

FILE: rtl/psa_ctrl.sv
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer: accepts a request, walks the slots, issues datapath commands.
// ----------------------------------------------------------------------------
module psa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  psa_pkg::sts_t sts_i,
  output psa_pkg::cmd_t cmd_o
);
  import psa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC, S_ADONE, S_TICK, S_ACT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (sts_i.action)
            ACT_ALLOC: state_d = S_ALLOC;
            ACT_TICK:  state_d = S_TICK;
            default:   state_d = S_ACT;
          endcase
        end
      end
      S_ALLOC: begin
        cmd_o.alloc_step = 1'b1;
        if (sts_i.idx_last) state_d = S_ADONE;
      end
      S_ADONE: begin
        if (sts_i.out_free) begin
          cmd_o.alloc_done = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_TICK: begin
        if (sts_i.out_free) begin
          cmd_o.tick_step = 1'b1;
          if (sts_i.idx_last) state_d = S_IDLE;
        end
      end
      S_ACT: begin
        if (sts_i.out_free) begin
          cmd_o.act_done = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

FILE: rtl/psa_dp.sv
// ----------------------------------------------------------------------------
// psa_dp
// Slot table, walk index, first-fit search and result register.
// ----------------------------------------------------------------------------
module psa_dp #(
  parameter int unsigned SLOTS     = psa_pkg::SlotsDef,
  parameter int unsigned RAM_BYTES = psa_pkg::RamBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      base_i,
  input  psa_pkg::item_t   item_i,
  input  psa_pkg::cmd_t    cmd_i,
  output psa_pkg::sts_t    sts_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output psa_pkg::result_t res_o
);
  import psa_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  slot_state_e     st_q   [SLOTS];
  logic [15:0]     loc_q  [SLOTS];
  logic [16:0]     size_q [SLOTS];
  logic [15:0]     sa_q   [SLOTS];
  logic [15:0]     pa_q   [SLOTS];
  logic [15:0]     ea_q   [SLOTS];

  item_t           item_q;
  logic [IW-1:0]   idx_q;
  logic [17:0]     start_q;   // end of the last active region seen
  logic [17:0]     cs_q;      // gap start for the pending candidate
  logic [IW-1:0]   cand_q;
  logic            pend_q, found_q;
  logic            out_valid_q;
  result_t         res_q;
  result_t         res_d;

  logic [16:0]     need;
  logic [17:0]     gap_end;
  logic            fits, slot_in, commit, res_ld, act_ok;
  logic [IW-1:0]   sidx;
  logic [15:0]     cs16, sa_n, pa_n, ea_n;
  slot_state_e     cur_st;

  assign need    = {1'b0, item_q.image_size} + {1'b0, item_q.extra_ram};
  assign cur_st  = st_q[idx_q];
  assign gap_end = found_q ? 18'(RAM_BYTES) :
                   (cur_st != ST_INACTIVE && cmd_i.alloc_step) ? {2'b00, loc_q[idx_q]}
                                                               : 18'(RAM_BYTES);
  assign fits    = pend_q && (gap_end >= cs_q) && ((gap_end - cs_q) >= {1'b0, need});
  assign slot_in = ({1'b0, item_q.slot} < 5'(SLOTS));
  assign sidx    = item_q.slot[IW-1:0];
  assign cs16    = cs_q[15:0];
  assign sa_n    = (item_q.start_offset != '0) ? base_i + cs16 + item_q.start_offset : '0;
  assign pa_n    = (item_q.proc_offset  != '0) ? base_i + cs16 + item_q.proc_offset  : '0;
  assign ea_n    = (item_q.exit_offset  != '0) ? base_i + cs16 + item_q.exit_offset  : '0;
  // final decision: either a hit during the walk or the tail gap up to RAM end
  assign commit  = (item_q.magic == Signature) && (need <= 17'(RAM_BYTES)) &&
                   (found_q || fits);
  assign res_ld  = cmd_i.alloc_done || cmd_i.tick_step || cmd_i.act_done;
  assign act_ok  = slot_in &&
                   (((action_e'(item_q.action) == ACT_MARK) && (st_q[sidx] == ST_LOADING)) ||
                    ((action_e'(item_q.action) != ACT_MARK) && (st_q[sidx] != ST_INACTIVE)));

  // the controller decodes the action of the beat on offer
  assign sts_o.action   = action_e'(item_i.action);
  assign sts_o.idx_last = (idx_q == IW'(SLOTS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign res_o          = res_q;

  // next result beat
  always_comb begin
    res_d      = '0;
    res_d.last = 1'b1;
    if (cmd_i.alloc_done) begin
      res_d.kind = KIND_ALLOC;
      if (item_q.magic != Signature) begin
        res_d.error_code = ERR_HEADER;
      end else if (!commit) begin
        res_d.error_code = ERR_NOMEM;
      end else begin
        res_d.ok         = 1'b1;
        res_d.slot_out   = 4'(cand_q);
        res_d.location   = base_i + cs16;
        res_d.start_addr = sa_n;
        res_d.proc_addr  = pa_n;
        res_d.exit_addr  = ea_n;
      end
    end else if (cmd_i.tick_step) begin
      res_d.kind     = KIND_TICK;
      res_d.ok       = 1'b1;
      res_d.slot_out = 4'(idx_q);
      res_d.last     = sts_o.idx_last;
      case (cur_st)
        ST_LOADED: if (sa_q[idx_q] != '0) begin
          res_d.call_kind = CALL_START;
          res_d.call_addr = sa_q[idx_q];
        end
        ST_RUNNING: if (pa_q[idx_q] != '0) begin
          res_d.call_kind = CALL_PROC;
          res_d.call_addr = pa_q[idx_q];
        end
        ST_EXITING: if (ea_q[idx_q] != '0) begin
          res_d.call_kind = CALL_EXIT;
          res_d.call_addr = ea_q[idx_q];
        end
        default: ;
      endcase
    end else begin
      res_d.kind     = KIND_STATUS;
      res_d.slot_out = item_q.slot;
      if (act_ok) begin
        res_d.ok = 1'b1;
      end else begin
        res_d.error_code = ERR_SLOT;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      for (int i = 0; i < SLOTS; i++) st_q[i] <= ST_INACTIVE;
    end else begin
      if (res_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.capture) begin
        idx_q   <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
      end
      if (cmd_i.alloc_step || cmd_i.tick_step) idx_q <= idx_q + 1'b1;
      if (cmd_i.alloc_step && !found_q) begin
        if (cur_st != ST_INACTIVE) begin
          if (fits) found_q <= 1'b1;
          else      pend_q  <= 1'b0;
        end else if (!pend_q) begin
          pend_q <= 1'b1;
        end
      end
      if (cmd_i.alloc_done && commit) st_q[cand_q] <= ST_LOADING;
      if (cmd_i.tick_step) begin
        case (cur_st)
          ST_LOADED:  st_q[idx_q] <= ST_RUNNING;
          ST_RUNNING: if (pa_q[idx_q] == '0) st_q[idx_q] <= ST_EXITING;
          ST_EXITING: st_q[idx_q] <= ST_INACTIVE;
          default: ;
        endcase
      end
      if (cmd_i.act_done && slot_in) begin
        if (action_e'(item_q.action) == ACT_MARK) begin
          if (st_q[sidx] == ST_LOADING) st_q[sidx] <= ST_LOADED;
        end else if (st_q[sidx] != ST_INACTIVE) begin
          st_q[sidx] <= ST_EXITING;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q  <= item_i;
      start_q <= '0;
    end
    if (cmd_i.alloc_step && !found_q) begin
      if (cur_st != ST_INACTIVE) begin
        start_q <= {2'b00, loc_q[idx_q]} + {1'b0, size_q[idx_q]};
      end else if (!pend_q) begin
        cs_q   <= start_q;
        cand_q <= idx_q;
      end
    end
    if (cmd_i.alloc_done && commit) begin
      loc_q[cand_q]  <= cs16;
      size_q[cand_q] <= need;
      sa_q[cand_q]   <= sa_n;
      pa_q[cand_q]   <= pa_n;
      ea_q[cand_q]   <= ea_n;
    end
    if (res_ld) res_q <= res_d;
  end
endmodule

FILE: rtl/process_slot_allocator.sv
// ----------------------------------------------------------------------------
// process_slot_allocator
// First-fit region allocator and lifecycle sequencer for a table of slots.
// ----------------------------------------------------------------------------
// Usage:
//  - in_i carries one request beat: allocate, tick, mark loaded or request
//    exit. out_o returns the result beats; the final beat of each
//    request has last set. A tick yields one beat per slot, in slot order.
//  - base_wr_i/base_wdata_i write the base address; write only while idle.
//  - One request at a time. Allocate: the walk visits one slot per cycle,
//    then the decision is loaded into the output register once it is free.
//    Tick: one beat per cycle while the receiver takes them, one per slot.
//    Mark/exit: the reply is loaded into the output register once it is free.
//  - Next request is taken once the previous one's final beat is loaded
//    into the output register, so it overlaps with that beat waiting.
//  - A stalled receiver holds the result register; a tick walk pauses with it, an allocate walk does not.
//  - Reset empties the table (all slots inactive) and restores the base.
// ----------------------------------------------------------------------------
module process_slot_allocator #(
  parameter int unsigned SLOTS     = psa_pkg::SlotsDef,
  parameter int unsigned RAM_BYTES = psa_pkg::RamBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        base_wr_i,
  input  logic [15:0] base_wdata_i,
  psa_in_if.sink      in_i,
  psa_out_if.source   out_o
);
  import psa_pkg::*;
  `include "process_slot_allocator_macros.svh"

  logic [15:0] base_q;
  cmd_t        cmd;
  sts_t        sts;
  item_t       item;
  result_t     res;
  logic        in_ready;

  // base register, relative offsets are added on output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else if (base_wr_i) begin
      base_q <= base_wdata_i;
    end
  end

  assign item.action       = in_i.action;
  assign item.magic        = in_i.magic;
  assign item.image_size   = in_i.image_size;
  assign item.extra_ram    = in_i.extra_ram;
  assign item.start_offset = in_i.start_offset;
  assign item.proc_offset  = in_i.proc_offset;
  assign item.exit_offset  = in_i.exit_offset;
  assign item.slot         = in_i.slot;
  assign in_i.ready        = in_ready;

  psa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psa_dp #(
    .SLOTS     (SLOTS),
    .RAM_BYTES (RAM_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_i      (base_q),
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .res_o       (res)
  );

  assign out_o.kind       = res.kind;
  assign out_o.ok         = res.ok;
  assign out_o.error_code = res.error_code;
  assign out_o.slot_out   = res.slot_out;
  assign out_o.location   = res.location;
  assign out_o.start_addr = res.start_addr;
  assign out_o.proc_addr  = res.proc_addr;
  assign out_o.exit_addr  = res.exit_addr;
  assign out_o.call_kind  = res.call_kind;
  assign out_o.call_addr  = res.call_addr;
  assign out_o.last       = res.last;

  // a request beat always starts work, so the port closes the cycle after
  `PSA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready, "request accepted but port still open")
  // only ticks give more than one beat
  `PSA_ASSERT_NOW(a_single_beat, clk_i, rst_ni, out_o.valid && out_o.kind != KIND_TICK, out_o.last, "non-tick result without last")
  // a tick's final beat is the top slot
  `PSA_ASSERT_NOW(a_tick_last_slot, clk_i, rst_ni, out_o.valid && out_o.kind == KIND_TICK && out_o.last, out_o.slot_out == 4'(SLOTS - 1), "tick ended on wrong slot")
  // failures carry an error code, successes none
  `PSA_ASSERT_NOW(a_ok_vs_err, clk_i, rst_ni, out_o.valid, out_o.ok == (out_o.error_code == ERR_NONE), "ok and error code disagree")
endmodule
